### src/rvie_pkg.sv
`default_nettype none

package rvie_pkg;

    // Reset values of the configuration registers
    localparam logic [31:0] START_PC_RESET = 32'h8000_0000;
    localparam logic [31:0] MEM_BASE_RESET = 32'h8000_0000;
    localparam int DMEM_BYTES_DEFAULT = 16384;

    // Configuration register indexes
    localparam logic CFG_START_PC = 1'b0;
    localparam logic CFG_MEM_BASE = 1'b1;

    // Major opcodes
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;

    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // Access size codes (funct3 low bits)
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EBREAK  = 2'd1,
        ST_INVALID = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    // Architectural effects of one instruction
    typedef struct packed {
        logic [31:0] next_pc;
        logic        rd_we;
        logic [4:0]  rd_index;
        logic [31:0] rd_value;
        logic        mem_we;
        logic [31:0] mem_addr;
        logic [31:0] mem_data;
        status_t     status;
    } exec_t;

    // Data memory request (offset from mem_base, in range only)
    typedef struct packed {
        logic        load;
        logic        store;
        logic [31:0] off;
        logic [1:0]  size;
        logic [31:0] wdata;
    } mreq_t;

endpackage

`default_nettype wire

### src/rvie_ram.sv
`default_nettype none

module rvie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/rvie_dmem.sv
`default_nettype none

module rvie_dmem #(
    parameter int DMEM_BYTES = rvie_pkg::DMEM_BYTES_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(DMEM_BYTES)-1:0] off,
    input  wire logic [1:0]                    size,
    input  wire logic [31:0]                   wdata,
    output logic      [31:0]                   rdata,
    output logic                               busy
);

    localparam int OFFW = $clog2(DMEM_BYTES);
    localparam int ROWS = (DMEM_BYTES + 3) / 4;
    localparam int RAW  = OFFW - 2;

    logic [RAW-1:0] clr_row_reg;
    logic [RAW-1:0] clr_row_next;
    logic           busy_reg;
    logic           busy_next;

    logic [1:0]     lo;
    logic [2:0]     nbytes;
    logic [1:0]     lane_i    [4];
    logic [RAW-1:0] lane_row  [4];
    logic           lane_we   [4];
    logic [RAW-1:0] lane_wa   [4];
    logic [7:0]     lane_wd   [4];
    logic [7:0]     lane_rd   [4];
    logic [OFFW:0]  lane_sum  [4];

    assign lo = off[1:0];

    always_comb
    begin
        case (size)
            rvie_pkg::SZ_BYTE: nbytes = 3'd1;
            rvie_pkg::SZ_HALF: nbytes = 3'd2;
            default:           nbytes = 3'd4;
        endcase
    end

    // Byte lanes: lane k holds bytes whose offset mod 4 is k
    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        always_comb
        begin
            lane_i[k]   = 2'(k) - lo;
            lane_sum[k] = {1'b0, off} + (OFFW + 1)'(lane_i[k]);
            lane_row[k] = lane_sum[k][OFFW-1:2];
            if (busy_reg)
            begin
                lane_we[k] = 1'b1;
                lane_wa[k] = clr_row_reg;
                lane_wd[k] = 8'h00;
            end
            else
            begin
                lane_we[k] = wr_en && ({1'b0, lane_i[k]} < nbytes);
                lane_wa[k] = lane_row[k];
                lane_wd[k] = wdata[8*lane_i[k] +: 8];
            end
        end

        rvie_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_lane (
            .clk   (clk),
            .we    (lane_we[k]),
            .waddr (lane_wa[k]),
            .wdata (lane_wd[k]),
            .re    (rd_en),
            .raddr (lane_row[k]),
            .rdata (lane_rd[k])
        );
    end

    // Reassemble little-endian word from the lanes
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rdata[8*i +: 8] = lane_rd[2'(i) + lo];
        end
    end

    // Clearing sweep after reset, one row per cycle
    always_comb
    begin
        clr_row_next = clr_row_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            if (clr_row_reg == RAW'(ROWS - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_row_next = clr_row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_row_reg <= clr_row_next;
            busy_reg    <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

### src/rvie_exec.sv
`default_nettype none

module rvie_exec #(
    parameter int DMEM_BYTES = rvie_pkg::DMEM_BYTES_DEFAULT
) (
    input  wire logic [31:0]     instr,
    input  wire logic [31:0]     pc,
    input  wire logic [31:0]     a,
    input  wire logic [31:0]     b,
    input  wire logic [31:0]     mem_base,
    input  wire logic [31:0]     load_data,
    output rvie_pkg::exec_t      res,
    output rvie_pkg::mreq_t      mreq
);

    localparam logic [31:0] LIM1 = 32'(DMEM_BYTES - 1);
    localparam logic [31:0] LIM2 = 32'(DMEM_BYTES - 2);
    localparam logic [31:0] LIM4 = 32'(DMEM_BYTES - 4);

    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic [31:0] pc4;
    logic [31:0] maddr;
    logic [31:0] moff;
    logic [31:0] lim;
    logic        range_ok;
    logic        wr;
    logic [31:0] val;
    logic        taken;

    assign op    = instr[6:0];
    assign rd    = instr[11:7];
    assign f3    = instr[14:12];
    assign f7    = instr[31:25];
    assign imm_i = {{20{instr[31]}}, instr[31:20]};
    assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_u = {instr[31:12], 12'h000};
    assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
    assign pc4   = pc + 32'd4;

    // Effective address and range check
    assign maddr = a + ((op == rvie_pkg::OP_STORE) ? imm_s : imm_i);
    assign moff  = maddr - mem_base;

    always_comb
    begin
        case (f3[1:0])
            rvie_pkg::SZ_BYTE: lim = LIM1;
            rvie_pkg::SZ_HALF: lim = LIM2;
            default:           lim = LIM4;
        endcase
    end

    assign range_ok = (moff <= lim);

    // Decode and execute
    always_comb
    begin
        wr           = 1'b0;
        val          = '0;
        taken        = 1'b0;
        res.next_pc  = pc4;
        res.mem_we   = 1'b0;
        res.mem_addr = '0;
        res.mem_data = '0;
        res.status   = rvie_pkg::ST_OK;
        mreq.load    = 1'b0;
        mreq.store   = 1'b0;
        mreq.off     = moff;
        mreq.size    = f3[1:0];
        mreq.wdata   = b;

        case (op)
            rvie_pkg::OP_LUI:
            begin
                wr  = 1'b1;
                val = imm_u;
            end
            rvie_pkg::OP_AUIPC:
            begin
                wr  = 1'b1;
                val = pc + imm_u;
            end
            rvie_pkg::OP_JAL:
            begin
                wr          = 1'b1;
                val         = pc4;
                res.next_pc = pc + imm_j;
            end
            rvie_pkg::OP_JALR:
            begin
                if (f3 != 3'd0)
                begin
                    res.status = rvie_pkg::ST_INVALID;
                end
                else
                begin
                    wr          = 1'b1;
                    val         = pc4;
                    res.next_pc = (a + imm_i) & ~32'd1;
                end
            end
            rvie_pkg::OP_BRANCH:
            begin
                case (f3)
                    3'd0: taken = (a == b);
                    3'd1: taken = (a != b);
                    3'd4: taken = ($signed(a) < $signed(b));
                    3'd5: taken = !($signed(a) < $signed(b));
                    3'd6: taken = (a < b);
                    3'd7: taken = (a >= b);
                    default: res.status = rvie_pkg::ST_INVALID;
                endcase
                if (taken)
                begin
                    res.next_pc = pc + imm_b;
                end
            end
            rvie_pkg::OP_LOAD:
            begin
                if (f3 inside {3'd3, 3'd6, 3'd7})
                begin
                    res.status = rvie_pkg::ST_INVALID;
                end
                else
                begin
                    res.mem_addr = maddr;
                    if (!range_ok)
                    begin
                        res.status = rvie_pkg::ST_RANGE;
                    end
                    else
                    begin
                        mreq.load = 1'b1;
                        wr        = 1'b1;
                        case (f3)
                            3'd0:    val = {{24{load_data[7]}}, load_data[7:0]};
                            3'd1:    val = {{16{load_data[15]}}, load_data[15:0]};
                            3'd4:    val = {24'h0, load_data[7:0]};
                            3'd5:    val = {16'h0, load_data[15:0]};
                            default: val = load_data;
                        endcase
                    end
                end
            end
            rvie_pkg::OP_STORE:
            begin
                if (f3 > 3'd2)
                begin
                    res.status = rvie_pkg::ST_INVALID;
                end
                else
                begin
                    res.mem_addr = maddr;
                    if (!range_ok)
                    begin
                        res.status = rvie_pkg::ST_RANGE;
                    end
                    else
                    begin
                        mreq.store = 1'b1;
                        res.mem_we = 1'b1;
                        case (f3[1:0])
                            rvie_pkg::SZ_BYTE: res.mem_data = {24'h0, b[7:0]};
                            rvie_pkg::SZ_HALF: res.mem_data = {16'h0, b[15:0]};
                            default:           res.mem_data = b;
                        endcase
                    end
                end
            end
            rvie_pkg::OP_IMM:
            begin
                wr = 1'b1;
                case (f3)
                    3'd0: val = a + imm_i;
                    3'd2: val = {31'h0, $signed(a) < $signed(imm_i)};
                    3'd3: val = {31'h0, a < imm_i};
                    3'd4: val = a ^ imm_i;
                    3'd6: val = a | imm_i;
                    3'd7: val = a & imm_i;
                    3'd1:
                    begin
                        if (f7 != rvie_pkg::F7_BASE)
                        begin
                            wr         = 1'b0;
                            res.status = rvie_pkg::ST_INVALID;
                        end
                        else
                        begin
                            val = a << instr[24:20];
                        end
                    end
                    default:
                    begin
                        if (f7 == rvie_pkg::F7_BASE)
                        begin
                            val = a >> instr[24:20];
                        end
                        else if (f7 == rvie_pkg::F7_ALT)
                        begin
                            val = 32'($signed(a) >>> instr[24:20]);
                        end
                        else
                        begin
                            wr         = 1'b0;
                            res.status = rvie_pkg::ST_INVALID;
                        end
                    end
                endcase
            end
            rvie_pkg::OP_REG:
            begin
                wr = 1'b1;
                if (f7 == rvie_pkg::F7_BASE)
                begin
                    case (f3)
                        3'd0:    val = a + b;
                        3'd1:    val = a << b[4:0];
                        3'd2:    val = {31'h0, $signed(a) < $signed(b)};
                        3'd3:    val = {31'h0, a < b};
                        3'd4:    val = a ^ b;
                        3'd5:    val = a >> b[4:0];
                        3'd6:    val = a | b;
                        default: val = a & b;
                    endcase
                end
                else if (f7 == rvie_pkg::F7_ALT && f3 == 3'd0)
                begin
                    val = a - b;
                end
                else if (f7 == rvie_pkg::F7_ALT && f3 == 3'd5)
                begin
                    val = 32'($signed(a) >>> b[4:0]);
                end
                else
                begin
                    wr         = 1'b0;
                    res.status = rvie_pkg::ST_INVALID;
                end
            end
            default:
            begin
                res.status = (instr == rvie_pkg::EBREAK_WORD) ? rvie_pkg::ST_EBREAK
                                                              : rvie_pkg::ST_INVALID;
            end
        endcase

        // x0 is never written
        res.rd_we    = wr && (rd != 5'd0);
        res.rd_index = res.rd_we ? rd : 5'd0;
        res.rd_value = res.rd_we ? val : 32'd0;
    end

endmodule

`default_nettype wire

### src/rv32i_instruction_executor_core.sv
`default_nettype none

// An accepted word is held in the execute stage, then its result is registered in the output stage.
// One instruction per cycle while the result stream is not stalled; an in-range load holds execute for its data read.
// The register file is read at accept time; writeback is forwarded to the next instruction.
// Reset: pc = 0x80000000, mem_base = 0x80000000, register file cleared through valid bits.
// After reset the data memory is cleared row by row; no word is taken meanwhile.
module rv32i_instruction_executor_core #(
    parameter int DMEM_BYTES = rvie_pkg::DMEM_BYTES_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data,
    // instruction stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // instr[31:0]
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [175:0] m_axis_tdata    // cur_pc[31:0], next_pc[63:32], rd_we[64],
                                              // rd_index[69:65], rd_value[101:70],
                                              // mem_we[102], mem_addr[134:103],
                                              // mem_data[166:135], status[168:167], zero
);

    localparam int OFFW = $clog2(DMEM_BYTES);

    logic            in_fire;
    logic            cfg_fire;
    logic            ex_adv;
    logic            ex_done;
    logic            wr_now;

    logic            ex_valid_reg;
    logic            ex_valid_next;
    logic [31:0]     ex_instr_reg;
    logic            ld_phase_reg;
    logic            ld_phase_next;
    logic [31:0]     pc_reg;
    logic [31:0]     pc_next;
    logic [31:0]     mem_base_reg;

    logic [31:0]     rf_valid_reg;
    logic            rs1_vld_reg;
    logic            rs2_vld_reg;
    logic            fwd_we_reg;
    logic [4:0]      fwd_idx_reg;
    logic [31:0]     fwd_val_reg;
    logic [31:0]     rf_rdata_a;
    logic [31:0]     rf_rdata_b;
    logic [31:0]     opa;
    logic [31:0]     opb;

    logic [31:0]     load_data;
    logic            dmem_busy;
    logic            dmem_rd;

    rvie_pkg::exec_t ex_res;
    rvie_pkg::mreq_t mreq;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [31:0]     out_pc_reg;
    rvie_pkg::exec_t out_res_reg;

    // Handshakes
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign ex_done       = !mreq.load || ld_phase_reg;
    assign ex_adv        = ex_valid_reg && ex_done && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !dmem_busy && (!ex_valid_reg || ex_adv);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign wr_now        = ex_adv && ex_res.rd_we;
    assign dmem_rd       = ex_valid_reg && mreq.load && !ld_phase_reg;

    // Register file: two copies for two read ports
    rvie_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_rf_a (
        .clk   (clk),
        .we    (wr_now),
        .waddr (ex_res.rd_index),
        .wdata (ex_res.rd_value),
        .re    (in_fire),
        .raddr (s_axis_tdata[19:15]),
        .rdata (rf_rdata_a)
    );

    rvie_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_rf_b (
        .clk   (clk),
        .we    (wr_now),
        .waddr (ex_res.rd_index),
        .wdata (ex_res.rd_value),
        .re    (in_fire),
        .raddr (s_axis_tdata[24:20]),
        .rdata (rf_rdata_b)
    );

    // Operand select: same-edge writeback, then stored value, else reset zero
    always_comb
    begin
        if (fwd_we_reg && fwd_idx_reg == ex_instr_reg[19:15])
        begin
            opa = fwd_val_reg;
        end
        else
        begin
            opa = rs1_vld_reg ? rf_rdata_a : 32'd0;
        end
        if (fwd_we_reg && fwd_idx_reg == ex_instr_reg[24:20])
        begin
            opb = fwd_val_reg;
        end
        else
        begin
            opb = rs2_vld_reg ? rf_rdata_b : 32'd0;
        end
    end

    rvie_exec #(
        .DMEM_BYTES (DMEM_BYTES)
    ) u_exec (
        .instr     (ex_instr_reg),
        .pc        (pc_reg),
        .a         (opa),
        .b         (opb),
        .mem_base  (mem_base_reg),
        .load_data (load_data),
        .res       (ex_res),
        .mreq      (mreq)
    );

    rvie_dmem #(
        .DMEM_BYTES (DMEM_BYTES)
    ) u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (dmem_rd),
        .wr_en (ex_adv && mreq.store),
        .off   (mreq.off[OFFW-1:0]),
        .size  (mreq.size),
        .wdata (mreq.wdata),
        .rdata (load_data),
        .busy  (dmem_busy)
    );

    // Stage control next state
    always_comb
    begin
        ex_valid_next = ex_valid_reg;
        if (in_fire)
        begin
            ex_valid_next = 1'b1;
        end
        else if (ex_adv)
        begin
            ex_valid_next = 1'b0;
        end

        ld_phase_next = ld_phase_reg;
        if (ex_adv)
        begin
            ld_phase_next = 1'b0;
        end
        else if (dmem_rd)
        begin
            ld_phase_next = 1'b1;
        end

        pc_next = pc_reg;
        if (cfg_fire && cfg_index == rvie_pkg::CFG_START_PC)
        begin
            pc_next = cfg_data;
        end
        else if (ex_adv)
        begin
            pc_next = ex_res.next_pc;
        end

        out_valid_next = out_valid_reg;
        if (ex_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            ld_phase_reg  <= 1'b0;
            pc_reg        <= rvie_pkg::START_PC_RESET;
            mem_base_reg  <= rvie_pkg::MEM_BASE_RESET;
            out_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
            fwd_we_reg    <= 1'b0;
        end
        else
        begin
            ex_valid_reg  <= ex_valid_next;
            ld_phase_reg  <= ld_phase_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_fire && cfg_index == rvie_pkg::CFG_MEM_BASE)
            begin
                mem_base_reg <= cfg_data;
            end
            if (wr_now)
            begin
                rf_valid_reg[ex_res.rd_index] <= 1'b1;
            end
            if (in_fire)
            begin
                fwd_we_reg <= wr_now;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ex_instr_reg <= s_axis_tdata;
            rs1_vld_reg  <= rf_valid_reg[s_axis_tdata[19:15]];
            rs2_vld_reg  <= rf_valid_reg[s_axis_tdata[24:20]];
            fwd_idx_reg  <= ex_res.rd_index;
            fwd_val_reg  <= ex_res.rd_value;
        end
        if (ex_adv)
        begin
            out_pc_reg  <= pc_reg;
            out_res_reg <= ex_res;
        end
    end

    // Result word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'h00,
                            out_res_reg.status,
                            out_res_reg.mem_data,
                            out_res_reg.mem_addr,
                            out_res_reg.mem_we,
                            out_res_reg.rd_value,
                            out_res_reg.rd_index,
                            out_res_reg.rd_we,
                            out_res_reg.next_pc,
                            out_pc_reg};

`ifndef ASSERT_OFF
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        dmem_busy |-> !in_fire)
        else $error("word accepted during memory clear");

    a_x0_never_written: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.rd_we && out_res_reg.rd_index == 5'd0))
        else $error("write to x0 reported");

    a_load_two_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_adv && mreq.load) |-> ld_phase_reg)
        else $error("load retired before data read");

    a_pc_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_adv && !(cfg_fire && cfg_index == rvie_pkg::CFG_START_PC))
        |=> pc_reg == $past(ex_res.next_pc))
        else $error("pc did not take next pc");

    a_store_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.mem_we) |-> out_res_reg.status == rvie_pkg::ST_OK)
        else $error("store with error status");
`endif

endmodule

`default_nettype wire
